/* sv/cpbsi_pkg.sv */
package cpbsi_pkg;

  // Item operation codes.
  typedef enum logic [2:0] {
    OP_REG_WR   = 3'd0,
    OP_REG_RD   = 3'd1,
    OP_SCANLINE = 3'd2,
    OP_MEM_RD   = 3'd3,
    OP_MEM_WR   = 3'd4
  } op_e;

  // PRG banking modes.
  typedef enum logic [1:0] {
    PRG_32K    = 2'd0,
    PRG_16K    = 2'd1,
    PRG_16K_8K = 2'd2,
    PRG_8K     = 2'd3
  } prg_mode_e;

  // Register addresses.
  localparam logic [15:0] ADDR_PRG_MODE   = 16'h5100;
  localparam logic [15:0] ADDR_RAM_KEY0   = 16'h5102;
  localparam logic [15:0] ADDR_RAM_KEY1   = 16'h5103;
  localparam logic [15:0] ADDR_RAM_PAGE   = 16'h5113;
  localparam logic [13:0] ADDR_PRG_BANK_W = 14'h1445;  // 5114-5117 without the low two bits
  localparam logic [15:0] ADDR_IRQ_TARGET = 16'h5203;
  localparam logic [15:0] ADDR_IRQ_STATUS = 16'h5204;
  localparam logic [15:0] ADDR_MUL_LO     = 16'h5205;
  localparam logic [15:0] ADDR_MUL_HI     = 16'h5206;

  // Memory windows.
  localparam logic [15:0] ADDR_RAM_BASE = 16'h6000;
  localparam logic [15:0] ADDR_ROM_BASE = 16'h8000;

  // First scanline outside the visible frame, counted one ahead.
  localparam logic [9:0] LINE_VBLANK = 10'd241;

  // Work RAM size codes.
  localparam logic [3:0] RSZ_NONE = 4'd0;
  localparam logic [3:0] RSZ_8K   = 4'd1;
  localparam logic [3:0] RSZ_16K  = 4'd2;
  localparam logic [3:0] RSZ_32K  = 4'd4;
  localparam logic [3:0] RSZ_64K  = 4'd8;

  // Write-protect unlock values.
  localparam logic [1:0] RAM_KEY0_UNLOCK = 2'd2;
  localparam logic [1:0] RAM_KEY1_UNLOCK = 2'd1;

  // Reset values.
  localparam logic [7:0] PRG_BANK_RESET = 8'hFF;
  localparam logic [1:0] RAM_KEY_RESET  = 2'd3;
  localparam logic [3:0] RSZ_RESET      = RSZ_64K;

  // Mapping state handed from the register file to the address translator.
  typedef struct packed {
    prg_mode_e       prg_mode;
    logic [3:0][7:0] prg_bank;
    logic [2:0]      ram_page;
    logic [3:0]      ram_size_code;
    logic [1:0]      ram_key0;
    logic [1:0]      ram_key1;
  } map_cfg_t;

endpackage

/* sv/cpbsi_xlate.sv */
module cpbsi_xlate (
  input  cpbsi_pkg::op_e      op_i,
  input  logic [15:0]         addr_i,
  input  cpbsi_pkg::map_cfg_t cfg_i,
  output logic                mapped_o,
  output logic                to_ram_o,
  output logic [6:0]          bank_o,
  output logic                write_enable_o
);
  import cpbsi_pkg::*;

  logic       is_mem;
  logic       is_ram;
  logic [2:0] ram_pg;
  logic [6:0] rom_bank;
  logic [1:0] slot;
  logic [7:0] r;
  logic       ram_present;
  logic [2:0] ram_bank;

  assign is_mem = (op_i == OP_MEM_RD) || (op_i == OP_MEM_WR);
  assign slot   = addr_i[14:13];

  // Select ROM bank or RAM page from the banking mode and slot.
  always_comb begin
    is_ram   = 1'b0;
    ram_pg   = 3'd0;
    rom_bank = 7'd0;
    r        = cfg_i.prg_bank[slot];
    if (addr_i < ADDR_ROM_BASE) begin
      is_ram = 1'b1;
      ram_pg = cfg_i.ram_page;
    end else begin
      unique case (cfg_i.prg_mode)
        PRG_32K: begin
          rom_bank = {cfg_i.prg_bank[3][6:2], slot};
        end
        PRG_16K, PRG_16K_8K: begin
          if (!slot[1]) begin
            if (cfg_i.prg_bank[1][7]) begin
              rom_bank = {cfg_i.prg_bank[1][6:1], slot[0]};
            end else begin
              is_ram = 1'b1;
              ram_pg = {cfg_i.prg_bank[1][2:1], slot[0]};
            end
          end else if (cfg_i.prg_mode == PRG_16K) begin
            rom_bank = {cfg_i.prg_bank[3][6:1], slot[0]};
          end else if (!slot[0]) begin
            if (cfg_i.prg_bank[2][7]) begin
              rom_bank = cfg_i.prg_bank[2][6:0];
            end else begin
              is_ram = 1'b1;
              ram_pg = cfg_i.prg_bank[2][2:0];
            end
          end else begin
            rom_bank = cfg_i.prg_bank[3][6:0];
          end
        end
        PRG_8K: begin
          if ((slot == 2'd3) || r[7]) begin
            rom_bank = r[6:0];
          end else begin
            is_ram = 1'b1;
            ram_pg = r[2:0];
          end
        end
        default: begin
          rom_bank = 7'd0;
        end
      endcase
    end
  end

  // Map a RAM page onto the fitted work RAM.
  always_comb begin
    ram_present = 1'b1;
    ram_bank    = 3'd0;
    unique case (cfg_i.ram_size_code)
      RSZ_NONE: ram_present = 1'b0;
      RSZ_8K:   ram_present = !ram_pg[2];
      RSZ_16K:  ram_bank    = {2'b00, ram_pg[2]};
      RSZ_32K: begin
        ram_present = !ram_pg[2];
        ram_bank    = ram_pg[2] ? 3'd0 : ram_pg;
      end
      RSZ_64K:  ram_bank    = ram_pg;
      default:  ram_bank    = 3'd0;
    endcase
  end

  // Combine into the result fields.
  always_comb begin
    mapped_o       = 1'b0;
    to_ram_o       = 1'b0;
    bank_o         = 7'd0;
    write_enable_o = 1'b0;
    if (is_mem && (addr_i >= ADDR_RAM_BASE)) begin
      if (is_ram) begin
        to_ram_o = 1'b1;
        mapped_o = ram_present;
        bank_o   = ram_present ? {4'd0, ram_bank} : 7'd0;
        write_enable_o = (op_i == OP_MEM_WR) && ram_present &&
                         (cfg_i.ram_key0 == RAM_KEY0_UNLOCK) &&
                         (cfg_i.ram_key1 == RAM_KEY1_UNLOCK);
      end else begin
        mapped_o = 1'b1;
        bank_o   = rom_bank;
      end
    end
  end

endmodule

/* sv/cpbsi_regs.sv */
module cpbsi_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_data_i,
  input  logic                fire_i,
  input  cpbsi_pkg::op_e      op_i,
  input  logic [15:0]         addr_i,
  input  logic [7:0]          data_i,
  input  logic [8:0]          scanline_i,
  input  logic                rendering_on_i,
  output logic [7:0]          read_data_o,
  output logic                read_driven_o,
  output logic                irq_line_o,
  output cpbsi_pkg::map_cfg_t cfg_o
);
  import cpbsi_pkg::*;

  logic [3:0]      ram_size_q;
  prg_mode_e       prg_mode_q, prg_mode_d;
  logic [3:0][7:0] prg_bank_q, prg_bank_d;
  logic [1:0]      key0_q, key0_d;
  logic [1:0]      key1_q, key1_d;
  logic [2:0]      ram_page_q, ram_page_d;
  logic [7:0]      irq_target_q, irq_target_d;
  logic            irq_en_q, irq_en_d;
  logic            in_frame_q, in_frame_d;
  logic            pending_q, pending_d;
  logic [7:0]      line_count_q, line_count_d;
  logic [7:0]      mul_a_q, mul_a_d;
  logic [7:0]      mul_b_q, mul_b_d;
  logic            irq_q, irq_d;
  logic [15:0]     product;
  logic [9:0]      line_next;
  logic [7:0]      line_inc;

  assign product   = 16'(mul_a_q) * 16'(mul_b_q);
  assign line_next = {1'b0, scanline_i} + 10'd1;
  assign line_inc  = line_count_q + 8'd1;

  // Next state and read data for the item in flight.
  always_comb begin
    prg_mode_d    = prg_mode_q;
    prg_bank_d    = prg_bank_q;
    key0_d        = key0_q;
    key1_d        = key1_q;
    ram_page_d    = ram_page_q;
    irq_target_d  = irq_target_q;
    irq_en_d      = irq_en_q;
    in_frame_d    = in_frame_q;
    pending_d     = pending_q;
    line_count_d  = line_count_q;
    mul_a_d       = mul_a_q;
    mul_b_d       = mul_b_q;
    irq_d         = irq_q;
    read_data_o   = 8'd0;
    read_driven_o = 1'b0;
    unique case (op_i)
      OP_REG_WR: begin
        if (addr_i == ADDR_PRG_MODE) begin
          prg_mode_d = prg_mode_e'(data_i[1:0]);
        end else if (addr_i == ADDR_RAM_KEY0) begin
          key0_d = data_i[1:0];
        end else if (addr_i == ADDR_RAM_KEY1) begin
          key1_d = data_i[1:0];
        end else if (addr_i == ADDR_RAM_PAGE) begin
          ram_page_d = data_i[2:0];
        end else if (addr_i[15:2] == ADDR_PRG_BANK_W) begin
          prg_bank_d[addr_i[1:0]] = data_i;
        end else if (addr_i == ADDR_IRQ_TARGET) begin
          irq_target_d = data_i;
          irq_d        = 1'b0;
        end else if (addr_i == ADDR_IRQ_STATUS) begin
          irq_en_d = data_i[7];
          irq_d    = 1'b0;
        end else if (addr_i == ADDR_MUL_LO) begin
          mul_a_d = data_i;
        end else if (addr_i == ADDR_MUL_HI) begin
          mul_b_d = data_i;
        end
      end
      OP_REG_RD: begin
        if (addr_i == ADDR_IRQ_STATUS) begin
          read_data_o   = {pending_q, in_frame_q, 6'd0};
          read_driven_o = 1'b1;
          pending_d     = 1'b0;
          irq_d         = 1'b0;
        end else if (addr_i == ADDR_MUL_LO) begin
          read_data_o   = product[7:0];
          read_driven_o = 1'b1;
        end else if (addr_i == ADDR_MUL_HI) begin
          read_data_o   = product[15:8];
          read_driven_o = 1'b1;
        end
      end
      OP_SCANLINE: begin
        if (!rendering_on_i || (line_next >= LINE_VBLANK)) begin
          in_frame_d   = 1'b0;
          pending_d    = 1'b0;
          line_count_d = 8'd0;
          irq_d        = 1'b0;
        end else if (!in_frame_q) begin
          in_frame_d   = 1'b1;
          pending_d    = 1'b0;
          line_count_d = 8'd0;
          irq_d        = 1'b0;
        end else begin
          line_count_d = line_inc;
          if (line_inc == irq_target_q) begin
            pending_d = 1'b1;
            if (irq_en_q) begin
              irq_d = 1'b1;
            end
          end
        end
      end
      default: begin
        read_driven_o = 1'b0;
      end
    endcase
  end

  // The IRQ level after this item.
  assign irq_line_o = irq_d;

  // State registers, updated as an item leaves the input register; the RAM size code is written on cfg_we_i.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_size_q   <= RSZ_RESET;
      prg_mode_q   <= PRG_8K;
      prg_bank_q   <= {4{PRG_BANK_RESET}};
      key0_q       <= RAM_KEY_RESET;
      key1_q       <= RAM_KEY_RESET;
      ram_page_q   <= 3'd0;
      irq_target_q <= 8'd0;
      irq_en_q     <= 1'b0;
      in_frame_q   <= 1'b0;
      pending_q    <= 1'b0;
      line_count_q <= 8'd0;
      mul_a_q      <= 8'd0;
      mul_b_q      <= 8'd0;
      irq_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ram_size_q <= cfg_data_i;
      end
      if (fire_i) begin
        prg_mode_q   <= prg_mode_d;
        prg_bank_q   <= prg_bank_d;
        key0_q       <= key0_d;
        key1_q       <= key1_d;
        ram_page_q   <= ram_page_d;
        irq_target_q <= irq_target_d;
        irq_en_q     <= irq_en_d;
        in_frame_q   <= in_frame_d;
        pending_q    <= pending_d;
        line_count_q <= line_count_d;
        mul_a_q      <= mul_a_d;
        mul_b_q      <= mul_b_d;
        irq_q        <= irq_d;
      end
    end
  end

  assign cfg_o.prg_mode      = prg_mode_q;
  assign cfg_o.prg_bank      = prg_bank_q;
  assign cfg_o.ram_page      = ram_page_q;
  assign cfg_o.ram_size_code = ram_size_q;
  assign cfg_o.ram_key0      = key0_q;
  assign cfg_o.ram_key1      = key1_q;

endmodule

/* sv/cartridge_prg_banking_and_scanline_irq_top.sv */
// An accepted item is held in the input register and then in the result register; it
// waits in the input register while the receiver stalls a held result.
// Throughput: one item per cycle while the receiver does not stall; the register update
// and address translation fit in the single logic stage between the two registers.
// Reset (rst_ni, asynchronous, active low) empties both registers and returns all
// mapper state to its power-on values; the work RAM size code resets to 64 KB.
module cartridge_prg_banking_and_scanline_irq_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [8:0]  scanline_i,
  input  logic        rendering_on_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        read_driven_o,
  output logic        irq_line_o,
  output logic        mapped_o,
  output logic        to_ram_o,
  output logic [6:0]  bank_o,
  output logic        write_enable_o
);
  import cpbsi_pkg::*;

  logic        s1_valid_q;
  op_e         s1_op_q;
  logic [15:0] s1_addr_q;
  logic [7:0]  s1_data_q;
  logic [8:0]  s1_line_q;
  logic        s1_rend_q;
  logic        out_free;
  logic        s1_fire;
  logic        in_fire;
  map_cfg_t    map_cfg;
  logic [7:0]  rd_data;
  logic        rd_driven;
  logic        irq_next;
  logic        x_mapped;
  logic        x_to_ram;
  logic [6:0]  x_bank;
  logic        x_we;

  // Handshake between the input register and the result register.
  assign out_free   = !out_valid_o || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= op_e'(operation_i);
      s1_addr_q <= address_i;
      s1_data_q <= write_data_i;
      s1_line_q <= scanline_i;
      s1_rend_q <= rendering_on_i;
    end
  end

  // Mapper registers, IRQ counter and register reads.
  cpbsi_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .fire_i         (s1_fire),
    .op_i           (s1_op_q),
    .addr_i         (s1_addr_q),
    .data_i         (s1_data_q),
    .scanline_i     (s1_line_q),
    .rendering_on_i (s1_rend_q),
    .read_data_o    (rd_data),
    .read_driven_o  (rd_driven),
    .irq_line_o     (irq_next),
    .cfg_o          (map_cfg)
  );

  // Memory address translation.
  cpbsi_xlate u_xlate (
    .op_i           (s1_op_q),
    .addr_i         (s1_addr_q),
    .cfg_i          (map_cfg),
    .mapped_o       (x_mapped),
    .to_ram_o       (x_to_ram),
    .bank_o         (x_bank),
    .write_enable_o (x_we)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_fire) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      read_data_o    <= rd_data;
      read_driven_o  <= rd_driven;
      irq_line_o     <= irq_next;
      mapped_o       <= x_mapped;
      to_ram_o       <= x_to_ram;
      bank_o         <= x_bank;
      write_enable_o <= x_we;
    end
  end

  // A result that drives the read bus never carries a memory mapping.
  a_read_not_mem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_driven_o |-> !mapped_o && !to_ram_o && !write_enable_o)
    else $error("register read result carries a memory mapping");

  // A permitted write always lands in present work RAM.
  a_we_ram : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_enable_o |-> mapped_o && to_ram_o)
    else $error("write permission outside present work RAM");

  // The input side stalls only behind a held result.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && s1_valid_q)
    else $error("input stalled without a held result");

  // A held result keeps its IRQ level.
  a_irq_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(irq_line_o))
    else $error("IRQ level changed under a held result");

endmodule

/* dv/tb_cartridge_prg_banking_and_scanline_irq_top.sv */
`timescale 1ns / 1ps

module tb_cartridge_prg_banking_and_scanline_irq_top;
  import cpbsi_pkg::*;

  // Operation codes that the block does not decode.
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

  // Size codes outside the supported set; they fold every page onto bank 0.
  localparam logic [3:0] RSZ_ODD_3 = 4'd3;
  localparam logic [3:0] RSZ_ODD_7 = 4'd7;

  localparam int HOLD_CYCLES = 40;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [8:0]  line;
    logic        rend;
  } bus_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_driven;
    logic       irq_line;
    logic       mapped;
    logic       to_ram;
    logic [6:0] bank;
    logic       write_enable;
  } bus_result_t;

  // Shadow copy of the mapper registers plus the results still owed by the block.
  class mapper_shadow;
    logic [3:0]  size_code;
    logic [7:0]  bank_reg [4];
    prg_mode_e   mode;
    logic [1:0]  key [2];
    logic [2:0]  page;
    logic [7:0]  target;
    logic        irq_en;
    logic        in_frame;
    logic        irq_flag;
    logic [7:0]  lines;
    logic [7:0]  mul [2];
    logic        irq_out;
    bus_result_t owed_q [$];
    int          errors;

    function new();
      size_code = RSZ_RESET;
      foreach (bank_reg[i]) bank_reg[i] = PRG_BANK_RESET;
      mode = PRG_8K;
      key[0] = RAM_KEY_RESET;
      key[1] = RAM_KEY_RESET;
      page = '0;
      target = '0;
      irq_en = 1'b0;
      in_frame = 1'b0;
      irq_flag = 1'b0;
      lines = '0;
      mul[0] = '0;
      mul[1] = '0;
      irq_out = 1'b0;
      errors = 0;
    endfunction

    function void set_ram_size(logic [3:0] code);
      size_code = code;
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction

    // Work RAM page to bank; returns 0 when the page is not populated.
    function bit ram_bank(logic [2:0] p, output logic [6:0] b);
      b = '0;
      case (size_code)
        RSZ_NONE: return 1'b0;
        RSZ_8K:   return !p[2];
        RSZ_16K: begin
          b = {6'd0, p[2]};
          return 1'b1;
        end
        RSZ_32K: begin
          if (!p[2]) b = {5'd0, p[1:0]};
          return !p[2];
        end
        RSZ_64K: begin
          b = {4'd0, p};
          return 1'b1;
        end
        default: return 1'b1;
      endcase
    endfunction

    // CPU address to ROM or RAM bank under the current banking mode.
    function void translate(logic [15:0] addr, output logic mapped, output logic to_ram,
                            output logic [6:0] bank);
      logic [1:0] slot;
      logic [7:0] r;
      logic [6:0] rom;
      logic [6:0] b;
      logic       is_ram;
      logic [2:0] rp;
      mapped = 1'b0;
      to_ram = 1'b0;
      bank = '0;
      rom = '0;
      is_ram = 1'b0;
      rp = '0;
      if (addr < ADDR_RAM_BASE) return;
      if (addr < ADDR_ROM_BASE) begin
        is_ram = 1'b1;
        rp = page;
      end else begin
        slot = addr[14:13];
        case (mode)
          PRG_32K: rom = {bank_reg[3][6:2], slot};
          PRG_16K, PRG_16K_8K: begin
            if (!slot[1]) begin
              r = bank_reg[1];
              if (r[7]) rom = {r[6:1], slot[0]};
              else begin
                is_ram = 1'b1;
                rp = {r[2:1], slot[0]};
              end
            end else if (mode == PRG_16K) begin
              rom = {bank_reg[3][6:1], slot[0]};
            end else if (!slot[0]) begin
              r = bank_reg[2];
              if (r[7]) rom = r[6:0];
              else begin
                is_ram = 1'b1;
                rp = r[2:0];
              end
            end else begin
              rom = bank_reg[3][6:0];
            end
          end
          default: begin
            r = bank_reg[slot];
            if (slot == 2'd3 || r[7]) rom = r[6:0];
            else begin
              is_ram = 1'b1;
              rp = r[2:0];
            end
          end
        endcase
      end
      if (is_ram) begin
        to_ram = 1'b1;
        mapped = ram_bank(rp, b);
        bank = mapped ? b : 7'd0;
      end else begin
        mapped = 1'b1;
        bank = rom;
      end
    endfunction

    // Apply one bus item to the shadow state and return what the block must answer.
    function bus_result_t step_mapper(bus_item_t it);
      bus_result_t res;
      logic [15:0] prod;
      logic [9:0]  next_line;
      res = '0;
      prod = {8'd0, mul[0]} * {8'd0, mul[1]};
      next_line = {1'b0, it.line} + 10'd1;
      case (it.op)
        OP_REG_WR: begin
          if (it.addr[15:2] == ADDR_PRG_BANK_W) begin
            bank_reg[it.addr[1:0]] = it.data;
          end else begin
            case (it.addr)
              ADDR_PRG_MODE: mode = prg_mode_e'(it.data[1:0]);
              ADDR_RAM_KEY0: key[0] = it.data[1:0];
              ADDR_RAM_KEY1: key[1] = it.data[1:0];
              ADDR_RAM_PAGE: page = it.data[2:0];
              ADDR_IRQ_TARGET: begin
                target = it.data;
                irq_out = 1'b0;
              end
              ADDR_IRQ_STATUS: begin
                irq_en = it.data[7];
                irq_out = 1'b0;
              end
              ADDR_MUL_LO: mul[0] = it.data;
              ADDR_MUL_HI: mul[1] = it.data;
              default: ;
            endcase
          end
        end
        OP_REG_RD: begin
          if (it.addr == ADDR_IRQ_STATUS) begin
            res.read_data = {irq_flag, in_frame, 6'd0};
            res.read_driven = 1'b1;
            irq_flag = 1'b0;
            irq_out = 1'b0;
          end else if (it.addr == ADDR_MUL_LO) begin
            res.read_data = prod[7:0];
            res.read_driven = 1'b1;
          end else if (it.addr == ADDR_MUL_HI) begin
            res.read_data = prod[15:8];
            res.read_driven = 1'b1;
          end
        end
        OP_SCANLINE: begin
          // Leaving the visible frame or starting a new one both restart the counter.
          if (!it.rend || next_line >= LINE_VBLANK) begin
            in_frame = 1'b0;
            irq_flag = 1'b0;
            lines = '0;
            irq_out = 1'b0;
          end else if (!in_frame) begin
            in_frame = 1'b1;
            irq_flag = 1'b0;
            lines = '0;
            irq_out = 1'b0;
          end else begin
            lines = lines + 8'd1;
            if (lines == target) begin
              irq_flag = 1'b1;
              if (irq_en) irq_out = 1'b1;
            end
          end
        end
        OP_MEM_RD, OP_MEM_WR: begin
          translate(it.addr, res.mapped, res.to_ram, res.bank);
          res.write_enable = (it.op == OP_MEM_WR) && res.mapped && res.to_ram &&
                             key[0] == RAM_KEY0_UNLOCK && key[1] == RAM_KEY1_UNLOCK;
        end
        default: ;
      endcase
      res.irq_line = irq_out;
      return res;
    endfunction

    function void note_item(bus_item_t it);
      owed_q.push_back(step_mapper(it));
    endfunction

    // Compare one result from the block with the oldest owed result.
    function void check_item(bus_result_t got);
      bus_result_t want;
      logic [7:0]  want_f [7];
      logic [7:0]  got_f [7];
      string       field [7] = '{"read_data", "read_driven", "irq_line", "mapped",
                                 "to_ram", "bank", "write_enable"};
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      want_f = '{want.read_data, 8'(want.read_driven), 8'(want.irq_line), 8'(want.mapped),
                 8'(want.to_ram), 8'(want.bank), 8'(want.write_enable)};
      got_f = '{got.read_data, 8'(got.read_driven), 8'(got.irq_line), 8'(got.mapped),
                8'(got.to_ram), 8'(got.bank), 8'(got.write_enable)};
      foreach (field[i]) begin
        if (want_f[i] !== got_f[i]) begin
          $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field[i],
                   want_f[i], got_f[i]);
          errors++;
        end
      end
    endfunction

    function void close_out();
      if (owed_q.size() != 0) begin
        $display("%0t: %0d results never arrived", $time, owed_q.size());
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [3:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  operation_i;
  logic [15:0] address_i;
  logic [7:0]  write_data_i;
  logic [8:0]  scanline_i;
  logic        rendering_on_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  read_data_o;
  logic        read_driven_o;
  logic        irq_line_o;
  logic        mapped_o;
  logic        to_ram_o;
  logic [6:0]  bank_o;
  logic        write_enable_o;

  mapper_shadow shadow;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  bit           hold_toggle = 1'b0;
  int           items_sent = 0;

  cartridge_prg_banking_and_scanline_irq_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .scanline_i     (scanline_i),
    .rendering_on_i (rendering_on_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_data_o    (read_data_o),
    .read_driven_o  (read_driven_o),
    .irq_line_o     (irq_line_o),
    .mapped_o       (mapped_o),
    .to_ram_o       (to_ram_o),
    .bank_o         (bank_o),
    .write_enable_o (write_enable_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Safety net against a hung handshake.
  initial begin
    #2000000;
    $display("[cartridge_prg_banking_and_scanline_irq_top] ERROR");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off when the toggle flips.
  initial begin : receiver
    int hold_left;
    bit seen_toggle;
    hold_left = 0;
    seen_toggle = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watch both handshakes; accepted items feed the shadow, results are checked.
  always @(posedge clk_i) begin : watch
    bus_item_t   seen_in;
    bus_result_t seen_out;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        seen_in = '{operation_i, address_i, write_data_i, scanline_i, rendering_on_i};
        shadow.note_item(seen_in);
      end
      if (out_valid_o && !out_stall_i) begin
        seen_out = '{read_data_o, read_driven_o, irq_line_o, mapped_o, to_ram_o, bank_o,
                     write_enable_o};
        shadow.check_item(seen_out);
      end
    end
  end

  // Offer one item, with an optional random gap first, and hold it until taken.
  task automatic send(input logic [2:0] op, input logic [15:0] addr, input logic [7:0] data,
                      input logic [8:0] line, input logic rend);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    address_i <= addr;
    write_data_i <= data;
    scanline_i <= line;
    rendering_on_i <= rend;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (shadow.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_ram_size(input logic [3:0] code);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= code;
    shadow.set_ram_size(code);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // A short frame: program a near target, then walk scanlines and leave the frame.
  task automatic frame_burst();
    int len;
    int first;
    send(OP_REG_WR, ADDR_IRQ_TARGET, 8'($urandom_range(12, 1)), 9'($urandom_range(261)),
         1'($urandom));
    if ($urandom_range(1) != 0)
      send(OP_REG_WR, ADDR_IRQ_STATUS, {1'($urandom_range(3) != 0), 7'($urandom)},
           9'($urandom_range(261)), 1'($urandom));
    len = $urandom_range(16, 2);
    first = $urandom_range(5);
    for (int i = 0; i < len; i++) begin
      send(OP_SCANLINE, 16'($urandom), 8'($urandom), 9'(first + i), $urandom_range(19) != 0);
      if ($urandom_range(4) == 0)
        send(OP_REG_RD, ADDR_IRQ_STATUS, 8'($urandom), 9'($urandom_range(261)), 1'($urandom));
    end
    send(OP_SCANLINE, 16'($urandom), 8'($urandom), 9'($urandom_range(261, 240)), 1'b1);
  endtask

  // A frame long enough for the line counter to wrap back to a target of zero.
  task automatic counter_wrap_frame();
    send(OP_REG_WR, ADDR_IRQ_TARGET, 8'h00, 9'd0, 1'b1);
    send(OP_REG_WR, ADDR_IRQ_STATUS, 8'h80, 9'd0, 1'b1);
    send(OP_SCANLINE, 16'($urandom), 8'($urandom), 9'd0, 1'b1);
    for (int i = 0; i < 257; i++)
      send(OP_SCANLINE, 16'($urandom), 8'($urandom), 9'($urandom_range(238)), 1'b1);
    send(OP_REG_RD, ADDR_IRQ_STATUS, 8'($urandom), 9'd0, 1'b0);
  endtask

  // One random step, weighted toward decoded registers and mapped memory.
  task automatic random_step();
    int          pick;
    logic [15:0] a;
    logic [7:0]  d;
    logic [15:0] reg_addrs [12] = '{ADDR_PRG_MODE, ADDR_RAM_KEY0, ADDR_RAM_KEY1,
                                    ADDR_RAM_PAGE, {ADDR_PRG_BANK_W, 2'd0},
                                    {ADDR_PRG_BANK_W, 2'd1}, {ADDR_PRG_BANK_W, 2'd2},
                                    {ADDR_PRG_BANK_W, 2'd3}, ADDR_IRQ_TARGET,
                                    ADDR_IRQ_STATUS, ADDR_MUL_LO, ADDR_MUL_HI};
    pick = $urandom_range(99);
    a = 16'($urandom);
    d = 8'($urandom);
    if (pick < 8) begin
      frame_burst();
    end else if (pick < 36) begin
      if ($urandom_range(9) != 0) a = reg_addrs[$urandom_range(11)];
      else if ($urandom_range(1) != 0) a = 16'h5100 + 16'($urandom_range(511));
      if (a == ADDR_RAM_KEY0 && $urandom_range(1) != 0) d[1:0] = RAM_KEY0_UNLOCK;
      if (a == ADDR_RAM_KEY1 && $urandom_range(1) != 0) d[1:0] = RAM_KEY1_UNLOCK;
      send(OP_REG_WR, a, d, 9'($urandom_range(261)), 1'($urandom));
    end else if (pick < 50) begin
      if ($urandom_range(4) != 0) a = reg_addrs[$urandom_range(11, 9)];
      send(OP_REG_RD, a, d, 9'($urandom_range(261)), 1'($urandom));
    end else if (pick < 60) begin
      send(OP_SCANLINE, a, d, 9'($urandom_range(261)), $urandom_range(3) != 0);
    end else if (pick < 96) begin
      if ($urandom_range(3) != 0) a = 16'($urandom_range(16'hFFFF, 16'h6000));
      send(($urandom_range(1) != 0) ? OP_MEM_WR : OP_MEM_RD, a, d, 9'($urandom_range(261)),
           1'($urandom));
    end else begin
      send(3'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED)), a, d,
           9'($urandom_range(261)), 1'($urandom));
    end
  endtask

  // Main sequence: reset, directed items, then random phases under several settings.
  initial begin : stimulus
    int         idle_tab [4] = '{0, 83, 0, 36};
    int         stall_tab [4] = '{0, 0, 83, 36};
    logic [3:0] size_tab [8] = '{RSZ_64K, RSZ_NONE, RSZ_8K, RSZ_16K, RSZ_32K, RSZ_ODD_3,
                                 RSZ_ODD_7, RSZ_64K};
    int         phase_end;
    bit         hold_done;
    shadow = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    operation_i = '0;
    address_i = '0;
    write_data_i = '0;
    scanline_i = '0;
    rendering_on_i = 1'b0;
    hold_done = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_ram_size(RSZ_64K);

    // Directed: reset status, full product, open bus, memory edges, unlock, a quick IRQ.
    send(OP_REG_RD, ADDR_IRQ_STATUS, 8'h00, 9'd0, 1'b0);
    send(OP_REG_WR, ADDR_MUL_LO, 8'hFF, 9'd261, 1'b1);
    send(OP_REG_WR, ADDR_MUL_HI, 8'hFF, 9'd0, 1'b0);
    send(OP_REG_RD, ADDR_MUL_LO, 8'h00, 9'd0, 1'b0);
    send(OP_REG_RD, ADDR_MUL_HI, 8'h00, 9'd0, 1'b0);
    send(OP_REG_RD, 16'h0000, 8'h00, 9'd0, 1'b0);
    send(OP_REG_WR, 16'hFFFF, 8'h00, 9'd0, 1'b0);
    send(OP_MEM_RD, ADDR_RAM_BASE - 16'd1, 8'h00, 9'd0, 1'b0);
    send(OP_MEM_RD, 16'hFFFF, 8'hFF, 9'd0, 1'b0);
    send(OP_REG_WR, ADDR_RAM_KEY0, {6'h3F, RAM_KEY0_UNLOCK}, 9'd0, 1'b0);
    send(OP_REG_WR, ADDR_RAM_KEY1, {6'h00, RAM_KEY1_UNLOCK}, 9'd0, 1'b0);
    send(OP_MEM_WR, ADDR_RAM_BASE, 8'h00, 9'd0, 1'b0);
    send(OP_MEM_RD, ADDR_ROM_BASE - 16'd1, 8'h00, 9'd0, 1'b0);
    send(OP_MEM_WR, ADDR_ROM_BASE, 8'h00, 9'd0, 1'b0);
    send(OP_LAST_UNUSED, 16'hFFFF, 8'hFF, 9'd261, 1'b1);
    send(OP_REG_WR, ADDR_IRQ_TARGET, 8'h01, 9'd0, 1'b0);
    send(OP_REG_WR, ADDR_IRQ_STATUS, 8'h80, 9'd0, 1'b0);
    send(OP_SCANLINE, 16'h0000, 8'h00, 9'd0, 1'b1);
    send(OP_SCANLINE, 16'h0000, 8'h00, 9'd1, 1'b1);
    send(OP_REG_RD, ADDR_IRQ_STATUS, 8'h00, 9'd0, 1'b0);
    send(OP_SCANLINE, 16'h0000, 8'h00, 9'd239, 1'b1);
    send(OP_SCANLINE, 16'h0000, 8'h00, 9'd240, 1'b1);
    send(OP_SCANLINE, 16'h0000, 8'h00, 9'd3, 1'b0);
    send(OP_FIRST_UNUSED, 16'h0000, 8'h00, 9'd0, 1'b0);

    // Random phases; each starts from an idle block and writes its RAM size code.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_ram_size(size_tab[ph]);
      send_idle_pct = idle_tab[ph % 4];
      recv_stall_pct <= stall_tab[ph % 4];
      phase_end = items_sent + 52;
      if (ph == 7) counter_wrap_frame();
      while (items_sent < phase_end) begin
        // Long receiver hold-off while items keep coming, so the input backs up.
        if (ph == 0 && !hold_done && items_sent >= phase_end - 50) begin
          hold_toggle <= ~hold_toggle;
          hold_done = 1'b1;
        end
        random_step();
      end
    end

    recv_stall_pct <= 0;
    drain();
    shadow.close_out();
    if (shadow.errors == 0) begin
      $display("[cartridge_prg_banking_and_scanline_irq_top] OK");
    end else begin
      $display("[cartridge_prg_banking_and_scanline_irq_top] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
sv/cpbsi_pkg.sv
sv/cpbsi_xlate.sv
sv/cpbsi_regs.sv
sv/cartridge_prg_banking_and_scanline_irq_top.sv
dv/tb_cartridge_prg_banking_and_scanline_irq_top.sv
